>>> rtl/core/l2vn_pkg.sv
// Shared constants and types for the L2 vector normalisation core.
package l2vn_pkg;

    localparam int MAX_LEN  = 64;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int ELEM_W   = 16;
    localparam int MAG_W    = 17;
    localparam int SQ_W     = 34;
    localparam int SUM_W    = 37;
    localparam int INV_W    = 30;
    localparam int K_W      = $clog2(INV_W);
    localparam int PROD_W   = MAG_W + INV_W;
    localparam int ISQ_W    = 102;
    localparam int NORM_W   = 16;
    localparam int Q14_ONE  = 16384;

    typedef logic [ELEM_W-1:0] elem_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [INV_W-1:0]  inv_t;

    // handshake between sequencer and inverse square root unit
    typedef struct packed {
        logic start;
        sum_t sum;
    } isq_req_t;

    typedef struct packed {
        logic done;
        inv_t inv;
    } isq_rsp_t;

endpackage

>>> rtl/core/l2vn_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module l2vn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/l2vn_isqrt.sv
// Bit-serial inverse square root: largest q with (2q-1)^2 * s <= 2^62.
module l2vn_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  l2vn_pkg::isq_req_t req,
    output l2vn_pkg::isq_rsp_t rsp
);
    import l2vn_pkg::*;

    localparam logic signed [ISQ_W-1:0] LIMIT = ISQ_W'(1) << 62;

    logic                    busy_reg, busy_next;
    logic                    phase_reg, phase_next;
    logic                    done_reg, done_next;
    logic [K_W-1:0]          k_reg, k_next;
    inv_t                    q_reg, q_next;
    logic signed [ISQ_W-1:0] p_reg, p_next;
    logic signed [ISQ_W-1:0] u_reg, u_next;
    logic signed [ISQ_W-1:0] x_reg, x_next;
    logic signed [ISQ_W-1:0] s_reg, s_next;
    logic [6:0]              sh_u;
    logic [6:0]              sh_s;
    logic signed [ISQ_W-1:0] cand;

    // t = 2q-1 held implicitly: p = t^2*s, u = t*s; a trial bit adds d = 2^(k+1) to t
    always_comb
    begin
        sh_u = 7'({2'b00, k_reg}) + 7'd2;
        sh_s = 7'({1'b0, k_reg, 1'b0}) + 7'd2;
        cand = x_reg + (s_reg <<< sh_s);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        k_next     = k_reg;
        q_next     = q_reg;
        p_next     = p_reg;
        u_next     = u_reg;
        x_next     = x_reg;
        s_next     = s_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            k_next     = K_W'(INV_W - 1);
            q_next     = '0;
            s_next     = ISQ_W'(req.sum);
            p_next     = ISQ_W'(req.sum);
            u_next     = -ISQ_W'(req.sum);
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                // cross term first
                x_next     = p_reg + (u_reg <<< sh_u);
                phase_next = 1'b1;
            end
            else
            begin
                if (cand <= LIMIT)
                begin
                    p_next = cand;
                    u_next = u_reg + (s_reg <<< (sh_u - 7'd1));
                    q_next = q_reg | (INV_W'(1) << k_reg);
                end
                phase_next = 1'b0;
                if (k_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    k_next = k_reg - K_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        q_reg <= q_next;
        p_reg <= p_next;
        u_reg <= u_next;
        x_reg <= x_next;
        s_reg <= s_next;
    end

    assign rsp.done = done_reg;
    assign rsp.inv  = q_reg;

endmodule

>>> rtl/core/l2_vector_normalize_core.sv
// L2 normalisation core: element buffer, sum of squares, inverse norm, readout.
// Load: one element a cycle into the buffer RAM while the sum of squares builds.
// After the last element the bit-serial unit forms the inverse norm, a cross-term
// step and a trial step per result bit; an all-zero vector skips the unit.
// Readout per result: RAM read, multiply, format, then output, held until taken.
// rst_n clears the control state and sums; the buffer RAM is not cleared.
module l2_vector_normalize_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [l2vn_pkg::ELEM_W-1:0]           s_tdata,  // [15:0] element
    input  logic                                  s_tlast,  // is_last
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [47:0]                           m_tdata,  // [15:0] normalized, [45:16] inv_norm
    output logic [1:0]                            m_tuser,  // [0] zero_vector, [1] overflowed
    output logic                                  m_tlast   // last_out
);
    import l2vn_pkg::*;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_FMT   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]          state_reg, state_next;
    sum_t                sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    rd_reg, rd_next;
    logic                drop_reg, drop_next;
    logic                zero_reg, zero_next;
    inv_t                inv_reg, inv_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                sign_reg, sign_next;
    logic                vld_reg, vld_next;
    logic [NORM_W-1:0]   norm_reg, norm_next;
    logic                last_reg, last_next;

    logic                in_acc, out_acc, store;
    logic [MAG_W-1:0]    in_mag, rd_mag;
    logic [SQ_W-1:0]     in_sq;
    elem_t               rdata;
    logic                re;
    logic [PROD_W:0]     rnd;
    logic [14:0]         qmag;
    isq_req_t            isq_req;
    isq_rsp_t            isq_rsp;

    assign s_tready = (state_reg == ST_LOAD);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = vld_reg && m_tready;
    assign store    = in_acc && (cnt_reg < CNT_W'(MAX_LEN));
    assign re       = (state_reg == ST_RD);

    // magnitudes and square
    always_comb
    begin
        in_mag = s_tdata[ELEM_W-1] ? (MAG_W'(0) - MAG_W'(s_tdata)) : MAG_W'(s_tdata);
        if (s_tdata[ELEM_W-1])
        begin
            in_mag = MAG_W'(17'h10000) - MAG_W'(s_tdata);
        end
        in_sq  = SQ_W'(in_mag) * SQ_W'(in_mag);
        rd_mag = rdata[ELEM_W-1] ? (MAG_W'(17'h10000) - MAG_W'(rdata)) : MAG_W'(rdata);
        rnd    = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(17'h08000);
        qmag   = ((rnd >> 16) > (PROD_W+1)'(Q14_ONE)) ? 15'(Q14_ONE) : rnd[30:16];
    end

    l2vn_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_LEN)
    ) u_ram (
        .clk   (clk),
        .we    (store),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .re    (re),
        .raddr (rd_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign isq_req.start = (state_reg == ST_START) && (sum_reg != '0);
    assign isq_req.sum   = sum_reg;

    l2vn_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (isq_req),
        .rsp   (isq_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        rd_next    = rd_reg;
        drop_next  = drop_reg;
        zero_next  = zero_reg;
        inv_next   = inv_reg;
        prod_next  = prod_reg;
        sign_next  = sign_reg;
        vld_next   = vld_reg;
        norm_next  = norm_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (store)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        sum_next = sum_reg + SUM_W'(in_sq);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                rd_next = '0;
                if (sum_reg == '0)
                begin
                    zero_next  = 1'b1;
                    inv_next   = '0;
                    state_next = ST_RD;
                end
                else
                begin
                    zero_next  = 1'b0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (isq_rsp.done)
                begin
                    inv_next   = isq_rsp.inv;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(rd_mag) * PROD_W'(inv_reg);
                sign_next  = rdata[ELEM_W-1];
                state_next = ST_FMT;
            end
            ST_FMT:
            begin
                norm_next  = (sign_reg && (qmag != '0)) ? (NORM_W'(0) - NORM_W'(qmag))
                                                        : NORM_W'(qmag);
                last_next  = (rd_reg == (cnt_reg - CNT_W'(1)));
                vld_next   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    vld_next = 1'b0;
                    if (last_reg)
                    begin
                        sum_next   = '0;
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        rd_next    = rd_reg + CNT_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            rd_reg    <= '0;
            drop_reg  <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            rd_reg    <= rd_next;
            drop_reg  <= drop_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        inv_reg  <= inv_next;
        prod_reg <= prod_next;
        sign_reg <= sign_next;
        norm_reg <= norm_next;
        last_reg <= last_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {2'b00, inv_reg, norm_reg};
    assign m_tuser  = {drop_reg, zero_reg};
    assign m_tlast  = last_reg;

`ifndef ASSERT_OFF
    // input is never taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted during readout");

    // a zero vector yields zero normalised elements
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[15:0] == 16'd0))
        else $error("non-zero element for zero vector");

    // accepting the final result of a run resets the element count
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (cnt_reg == '0 && s_tready))
        else $error("run state not cleared after readout");
`endif

endmodule
